FILE: design/hmac_sha1_engine_top_defines.svh
// Assertion macros for the HMAC-SHA1 engine.
`ifndef HMAC_SHA1_ENGINE_TOP_DEFINES_SVH
`define HMAC_SHA1_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HS_ASSERT(label, clk, rst, prop, msg)
`define HS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: design/hs1_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// hs1_pkg
// Shared types, constants and round helpers for the HMAC-SHA1 engine.
// ------------------------------------------------------------------------
package hs1_pkg;

  localparam int unsigned KeyWords = 8;
  localparam int unsigned KeyIdxW  = $clog2(KeyWords);
  localparam logic [31:0] Ipad = 32'h36363636;
  localparam logic [31:0] Opad = 32'h5c5c5c5c;

  typedef logic [31:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IPAD_LOAD,
    ST_IPAD_RUN,
    ST_ACCEPT,
    ST_MSG_RUN,
    ST_PAD,
    ST_PAD_RUN,
    ST_OPAD_LOAD,
    ST_OPAD_RUN,
    ST_OUTER_LOAD,
    ST_OUTER_RUN,
    ST_EMIT
  } state_t;

  // Block source chosen by a block load.
  typedef enum logic [1:0] {
    SRC_IPAD,
    SRC_OPAD,
    SRC_OUTER
  } src_t;

  // Controller to datapath.
  typedef struct packed {
    logic       init_chain;   // load initial values into chain
    logic       load_block;   // fill block buffer from src
    src_t       src;
    logic       absorb;       // write byte into block
    logic [7:0] absorb_byte;
    logic       count_msg;    // bump message byte count
    logic       write_len;    // put bit length in words 14,15
    logic       start;        // begin 80 rounds
    logic       save_inner;   // copy chain into inner digest
    logic       clear_fill;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       busy;
    logic [5:0] fill;
  } stat_t;

  function automatic word_t sha_iv(input logic [2:0] i);
    case (i)
      3'd0: sha_iv = 32'h67452301;
      3'd1: sha_iv = 32'hefcdab89;
      3'd2: sha_iv = 32'h98badcfe;
      3'd3: sha_iv = 32'h10325476;
      default: sha_iv = 32'hc3d2e1f0;
    endcase
  endfunction

  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    rotl = (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

endpackage

FILE: design/hmac_sha1_engine_top.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// hmac_sha1_engine_top
// HMAC-SHA1 over a byte stream with a 64-byte key in eight registers.
// ------------------------------------------------------------------------
// One SHA-1 round per clock; a block holds the round unit until its last
// round is added into the chain. The first beat of a message waits while
// the ipad block is hashed (an idle state, a load state, then the run
// state). Message bytes are then taken one per cycle; the beat that fills
// a 64-byte block holds off input until that block has been hashed.
// After the ending beat the padding bytes go in one per cycle up to
// offset 55 (with an extra block of padding when fewer than 9 bytes are
// free), then the last inner block, the opad block and the outer block
// are hashed, and five digest beats follow, each held until accepted.
module hmac_sha1_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [hs1_pkg::KeyIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic        s_tuser,   // has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros
  output logic        m_tlast    // last_word
);

  logic [63:0] key [hs1_pkg::KeyWords];
  hs1_pkg::cmd_t  cmd;
  hs1_pkg::stat_t stat;
  logic [159:0] digest;
  logic [2:0] idx;
  logic [31:0] word;

  // Key registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < hs1_pkg::KeyWords; j++) key[j] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  hs1_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_byte(s_tdata),
    .in_has(s_tuser), .in_end(s_tlast),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_idx(idx),
    .cmd(cmd), .stat(stat)
  );

  hs1_datapath u_dp (
    .clk(clk), .rst(rst), .key(key), .cmd(cmd), .stat(stat), .digest(digest)
  );

  // Pick the digest word of this beat, most significant first.
  always_comb begin
    case (idx)
      3'd0: word = digest[159:128];
      3'd1: word = digest[127:96];
      3'd2: word = digest[95:64];
      3'd3: word = digest[63:32];
      default: word = digest[31:0];
    endcase
  end

  assign m_tdata = {5'd0, idx, word};
  assign m_tlast = (idx == 3'd4);

endmodule

FILE: design/hs1_datapath.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// hs1_datapath
// Block buffer, chain value, inner digest and one SHA-1 round per cycle.
// ------------------------------------------------------------------------
`include "hmac_sha1_engine_top_defines.svh"
module hs1_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         key [hs1_pkg::KeyWords],
  input  hs1_pkg::cmd_t       cmd,
  output hs1_pkg::stat_t      stat,
  output logic [159:0]        digest
);

  hs1_pkg::word_t w [16];
  hs1_pkg::word_t h [5];
  hs1_pkg::word_t inner [5];
  hs1_pkg::word_t a, b, c, d, e;
  logic [6:0]  round;
  logic        busy;
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic [63:0] bits;

  hs1_pkg::word_t f, k, wt, wx, tmp;

  assign bits = {msg_bytes + 61'd64, 3'b000};

  // Round function and schedule word.
  always_comb begin
    wx = hs1_pkg::rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 5'd1);
    wt = (round < 7'd16) ? w[0] : wx;
    if (round < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5a827999;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ed9eba1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
    end else begin
      f = b ^ c ^ d; k = 32'hca62c1d6;
    end
    tmp = hs1_pkg::rotl(a, 5'd5) + f + e + k + wt;
  end

  // Advance rounds; window w[0] is the word of rounds 0 to 15, later words come from the schedule.
  always_ff @(posedge clk) begin
    if (busy) begin
      for (int j = 0; j < 15; j++) w[j] <= w[j+1];
      w[15] <= wt;
      e <= d; d <= c; c <= hs1_pkg::rotl(b, 5'd30); b <= a; a <= tmp;
    end else if (cmd.load_block) begin
      case (cmd.src)
        hs1_pkg::SRC_IPAD: begin
          for (int j = 0; j < 16; j++)
            w[j] <= (j[0] ? key[j/2][31:0] : key[j/2][63:32]) ^ hs1_pkg::Ipad;
        end
        hs1_pkg::SRC_OPAD: begin
          for (int j = 0; j < 16; j++)
            w[j] <= (j[0] ? key[j/2][31:0] : key[j/2][63:32]) ^ hs1_pkg::Opad;
        end
        default: begin
          // Inner digest, pad bit and the bit length of the outer message.
          for (int j = 0; j < 5; j++) w[j] <= inner[j];
          w[5] <= 32'h80000000;
          for (int j = 6; j < 15; j++) w[j] <= '0;
          w[15] <= 32'd672;
        end
      endcase
    end else begin
      if (cmd.absorb) begin
        for (int j = 0; j < 16; j++) begin
          if (fill[5:2] == j[3:0]) begin
            case (fill[1:0])
              2'd0: w[j] <= {cmd.absorb_byte, 24'h0};
              2'd1: w[j][23:16] <= cmd.absorb_byte;
              2'd2: w[j][15:8] <= cmd.absorb_byte;
              default: w[j][7:0] <= cmd.absorb_byte;
            endcase
          end
        end
      end
      if (cmd.write_len) begin
        w[14] <= bits[63:32];
        w[15] <= bits[31:0];
      end
    end
    if (cmd.start) begin
      a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
    end
    if (cmd.save_inner) begin
      for (int j = 0; j < 5; j++) inner[j] <= h[j];
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; round <= '0; fill <= '0; msg_bytes <= '0;
      for (int j = 0; j < 5; j++) h[j] <= hs1_pkg::sha_iv(3'(j));
    end else begin
      if (cmd.start) begin
        busy <= 1'b1; round <= '0;
      end else if (busy) begin
        round <= round + 7'd1;
        if (round == 7'd79) begin
          busy <= 1'b0;
          h[0] <= h[0] + tmp; h[1] <= h[1] + a; h[2] <= h[2] + hs1_pkg::rotl(b, 5'd30);
          h[3] <= h[3] + c; h[4] <= h[4] + d;
        end
      end
      if (cmd.init_chain) begin
        for (int j = 0; j < 5; j++) h[j] <= hs1_pkg::sha_iv(3'(j));
      end
      if (cmd.clear_fill) begin
        fill <= '0; msg_bytes <= '0;
      end else begin
        if (cmd.absorb) fill <= fill + 6'd1;
        if (cmd.count_msg) msg_bytes <= msg_bytes + 61'd1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.fill = fill;
  assign digest = {h[0], h[1], h[2], h[3], h[4]};

  `HS_ASSERT(a_round_range, clk, rst, busy |-> round < 7'd80, "round past 79")
  `HS_ASSERT(a_no_restart, clk, rst, busy |-> !cmd.start, "start while busy")
  `HS_ASSERT(a_no_absorb_busy, clk, rst, busy |-> !cmd.absorb, "absorb while busy")

endmodule

FILE: design/hs1_ctrl.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// hs1_ctrl
// Sequencer: input handshake, padding, inner/outer hash and digest beats.
// ------------------------------------------------------------------------
`include "hmac_sha1_engine_top_defines.svh"
module hs1_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_has,
  input  logic            in_end,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_idx,
  output hs1_pkg::cmd_t   cmd,
  input  hs1_pkg::stat_t  stat
);

  hs1_pkg::state_t state, state_next;
  logic ending, ending_next;
  logic [2:0] idx, idx_next;
  logic fire;
  logic pad_first, pad_first_next;

  assign fire = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    ending_next = ending;
    idx_next = idx;
    pad_first_next = pad_first;
    case (state)
      hs1_pkg::ST_IDLE: if (in_valid) state_next = hs1_pkg::ST_IPAD_LOAD;
      hs1_pkg::ST_IPAD_LOAD: state_next = hs1_pkg::ST_IPAD_RUN;
      hs1_pkg::ST_IPAD_RUN: if (!stat.busy) state_next = hs1_pkg::ST_ACCEPT;
      hs1_pkg::ST_ACCEPT: begin
        if (fire) begin
          ending_next = in_end;
          pad_first_next = 1'b1;
          if (in_has && stat.fill == 6'd63) state_next = hs1_pkg::ST_MSG_RUN;
          else if (in_end) state_next = hs1_pkg::ST_PAD;
        end
      end
      hs1_pkg::ST_MSG_RUN:
        if (!stat.busy) state_next = ending ? hs1_pkg::ST_PAD : hs1_pkg::ST_ACCEPT;
      hs1_pkg::ST_PAD: begin
        pad_first_next = 1'b0;
        if (stat.fill == 6'd63 || stat.fill == 6'd55) state_next = hs1_pkg::ST_PAD_RUN;
      end
      // A wrapped fill means the length still needs a block of its own.
      hs1_pkg::ST_PAD_RUN:
        if (!stat.busy) begin
          if (stat.fill == 6'd0) state_next = hs1_pkg::ST_PAD;
          else state_next = hs1_pkg::ST_OPAD_LOAD;
        end
      hs1_pkg::ST_OPAD_LOAD: state_next = hs1_pkg::ST_OPAD_RUN;
      hs1_pkg::ST_OPAD_RUN: if (!stat.busy) state_next = hs1_pkg::ST_OUTER_LOAD;
      hs1_pkg::ST_OUTER_LOAD: state_next = hs1_pkg::ST_OUTER_RUN;
      hs1_pkg::ST_OUTER_RUN: if (!stat.busy) begin
        state_next = hs1_pkg::ST_EMIT; idx_next = '0;
      end
      hs1_pkg::ST_EMIT: if (out_ready) begin
        if (idx == 3'd4) begin
          state_next = hs1_pkg::ST_IDLE; idx_next = '0;
        end else begin
          idx_next = idx + 3'd1;
        end
      end
      default: state_next = hs1_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.src = hs1_pkg::SRC_IPAD;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      // Chain already holds the initial values; load ipad and start.
      hs1_pkg::ST_IPAD_LOAD: begin
        cmd.load_block = 1'b1; cmd.clear_fill = 1'b1; cmd.start = 1'b1;
        cmd.src = hs1_pkg::SRC_IPAD;
      end
      hs1_pkg::ST_ACCEPT: begin
        in_ready = 1'b1;
        cmd.absorb = fire && in_has;
        cmd.count_msg = fire && in_has;
        cmd.absorb_byte = in_byte;
        cmd.start = fire && in_has && stat.fill == 6'd63;
      end
      hs1_pkg::ST_PAD: begin
        cmd.absorb = 1'b1;
        cmd.absorb_byte = pad_first ? 8'h80 : 8'h00;
        cmd.write_len = (stat.fill == 6'd55);
        cmd.start = (stat.fill == 6'd63) || (stat.fill == 6'd55);
      end
      // Keep the inner digest and reload the initial values for opad.
      hs1_pkg::ST_PAD_RUN: begin
        cmd.save_inner = !stat.busy && (stat.fill != 6'd0);
        cmd.init_chain = !stat.busy && (stat.fill != 6'd0);
      end
      hs1_pkg::ST_OPAD_LOAD: begin
        cmd.load_block = 1'b1; cmd.start = 1'b1; cmd.src = hs1_pkg::SRC_OPAD;
      end
      hs1_pkg::ST_OUTER_LOAD: begin
        cmd.load_block = 1'b1; cmd.start = 1'b1; cmd.src = hs1_pkg::SRC_OUTER;
      end
      // Restore the initial values once the last beat leaves.
      hs1_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.init_chain = out_ready && (idx == 3'd4);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hs1_pkg::ST_IDLE; ending <= 1'b0; idx <= '0; pad_first <= 1'b0;
    end else begin
      state <= state_next; ending <= ending_next; idx <= idx_next;
      pad_first <= pad_first_next;
    end
  end

  assign out_idx = idx;

  `HS_ASSERT(a_out_idx, clk, rst, out_valid |-> idx <= 3'd4, "index past 4")
  `HS_ASSERT(a_excl, clk, rst, !(in_ready && out_valid), "accept while emitting")
  `HS_ASSERT(a_start_idle, clk, rst, cmd.start |-> !stat.busy, "start while rounds run")

endmodule
